// ===== src/mbpe_pkg.sv =====
// ----------------------------------------------------------------------------
// Mono bitmap pixel expander package
// Shared constants, register indexes and the queue entry type.
// ----------------------------------------------------------------------------
package mbpe_pkg;

   // Side limits of the image
   localparam int unsigned SIDE_W   = 9;
   localparam int unsigned MAX_SIDE = 320;

   // Colour and configuration data widths
   localparam int unsigned COLOUR_W = 16;
   localparam int unsigned CSR_IDX_W = 3;

   // Default depth of the front-to-back queue
   localparam int unsigned QUEUE_DEPTH = 4;

   // Register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_FG_COLOUR    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BG_COLOUR    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 3'd3;

   // Reset values of the configuration registers
   localparam logic [COLOUR_W-1:0] FG_RESET     = 16'h0000;
   localparam logic [COLOUR_W-1:0] BG_RESET     = 16'hFFFF;
   localparam logic [SIDE_W-1:0]   WIDTH_RESET  = 9'd1;
   localparam logic [SIDE_W-1:0]   HEIGHT_RESET = 9'd1;

   // One classified byte, as handed from the front to the back
   typedef struct packed {
      logic [7:0] image_byte;  // bitmap bits, leftmost pixel in bit 7
      logic [2:0] last_idx;    // index of the last pixel to emit (count - 1)
      logic       ends_row;
      logic       ends_image;
   } entry_type;

   // Clamp a side register: zero acts as one, oversize saturates
   function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] v);
      logic [SIDE_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = SIDE_W'(1);
      end else if (v > SIDE_W'(MAX_SIDE)) begin
         r = SIDE_W'(MAX_SIDE);
      end
      return r;
   endfunction

endpackage

// ===== src/mbpe_front.sv =====
// ----------------------------------------------------------------------------
// Mono bitmap pixel expander front
// Accepts bitmap bytes, tracks column and row, and classifies each byte.
// ----------------------------------------------------------------------------
module mbpe_front
   import mbpe_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic [SIDE_W-1:0] image_width,
   input  logic [SIDE_W-1:0] image_height,
   input  logic              req_valid,
   input  logic [7:0]        req_image_byte,
   input  logic              queue_full,
   output logic              req_stall,
   output logic              push,
   output entry_type         push_entry
);

   logic [SIDE_W-1:0] col_ff, col_in;
   logic [SIDE_W-1:0] row_ff, row_in;

   logic [SIDE_W-1:0] width_eff;
   logic [SIDE_W-1:0] height_eff;
   logic [SIDE_W-1:0] col_eff;
   logic [SIDE_W-1:0] row_eff;
   logic [SIDE_W-1:0] remaining;
   logic              ends_row;
   logic              ends_image;

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   // Effective sides and stale counter restart
   always_comb begin
      width_eff  = clamp_side(image_width);
      height_eff = clamp_side(image_height);
      col_eff    = (col_ff >= width_eff)  ? '0 : col_ff;
      row_eff    = (row_ff >= height_eff) ? '0 : row_ff;
   end

   // Classify the byte: pixel count and row/image end
   always_comb begin
      remaining  = width_eff - col_eff;
      ends_row   = (remaining <= SIDE_W'(8));
      ends_image = ends_row &&
                   (({1'b0, row_eff} + (SIDE_W+1)'(1)) == {1'b0, height_eff});
      push_entry.image_byte = req_image_byte;
      push_entry.last_idx   = ends_row ? 3'(remaining - SIDE_W'(1)) : 3'd7;
      push_entry.ends_row   = ends_row;
      push_entry.ends_image = ends_image;
   end

   // Counter update on accept
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (push) begin
         if (ends_row) begin
            col_in = '0;
            row_in = ends_image ? '0 : SIDE_W'(row_eff + SIDE_W'(1));
         end else begin
            col_in = SIDE_W'(col_eff + SIDE_W'(8));
            row_in = row_eff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Image end brings both counters back to zero
   a_image_end_clears: assert property (@(posedge clock) disable iff (reset)
      push && push_entry.ends_image |=> (col_ff == '0) && (row_ff == '0))
      else $error("counters not cleared after image end");

   // An image end is always a row end
   a_image_implies_row: assert property (@(posedge clock) disable iff (reset)
      push && push_entry.ends_image |-> push_entry.ends_row)
      else $error("image end without row end");

endmodule

// ===== src/mbpe_queue.sv =====
// ----------------------------------------------------------------------------
// Mono bitmap pixel expander queue
// Short FIFO of classified bytes between the front and the back.
// ----------------------------------------------------------------------------
module mbpe_queue
   import mbpe_pkg::*;
#(
   parameter int unsigned DEPTH = QUEUE_DEPTH
)
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   input  logic      pop,
   output logic      full,
   output logic      not_empty,
   output entry_type head
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   entry_type         mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = mem_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_ff + PTR_W'(1));
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_ff + PTR_W'(1));
      end
      if (push && !pop) begin
         count_in = CNT_W'(count_ff + CNT_W'(1));
      end else if (pop && !push) begin
         count_in = CNT_W'(count_ff - CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full && !pop))
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && !not_empty))
      else $error("pop from empty queue");

endmodule

// ===== src/mbpe_back.sv =====
// ----------------------------------------------------------------------------
// Mono bitmap pixel expander back
// Expands one queued byte into its pixels, one pixel per cycle while rsp_stall is low.
// ----------------------------------------------------------------------------
module mbpe_back
   import mbpe_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic [COLOUR_W-1:0] fg_colour,
   input  logic [COLOUR_W-1:0] bg_colour,
   input  logic                q_not_empty,
   input  entry_type           q_head,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [COLOUR_W-1:0] rsp_pixel_word,
   output logic                rsp_byte_done,
   output logic                rsp_row_done,
   output logic                rsp_image_done
);

   logic                busy_ff, busy_in;
   entry_type           cur_ff, cur_in;
   logic [2:0]          k_ff, k_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [COLOUR_W-1:0] pixel_ff;
   logic                byte_done_ff;
   logic                row_done_ff;
   logic                image_done_ff;

   logic                load_out;
   logic                emit;
   logic                last_pix;
   logic                item_end;
   logic [COLOUR_W-1:0] colour;

   // Output register is free when empty or being taken
   always_comb begin
      load_out = !rsp_valid_ff || !rsp_stall;
      emit     = busy_ff && load_out;
      last_pix = (k_ff == cur_ff.last_idx);
      item_end = emit && last_pix;
      pop      = q_not_empty && (!busy_ff || item_end);
      colour   = cur_ff.image_byte[7] ? bg_colour : fg_colour;
   end

   // Current byte: load on pop, shift one bit per emitted pixel
   always_comb begin
      busy_in = busy_ff;
      cur_in  = cur_ff;
      k_in    = k_ff;
      if (pop) begin
         busy_in = 1'b1;
         cur_in  = q_head;
         k_in    = '0;
      end else if (emit) begin
         cur_in.image_byte = {cur_ff.image_byte[6:0], 1'b0};
         k_in              = 3'(k_ff + 3'd1);
         if (last_pix) begin
            busy_in = 1'b0;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (load_out) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (emit) begin
         pixel_ff      <= {colour[7:0], colour[15:8]};
         byte_done_ff  <= last_pix;
         row_done_ff   <= last_pix && cur_ff.ends_row;
         image_done_ff <= last_pix && cur_ff.ends_image;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pixel_word = pixel_ff;
   assign rsp_byte_done  = byte_done_ff;
   assign rsp_row_done   = row_done_ff;
   assign rsp_image_done = image_done_ff;

   // A row end is always on the last pixel of a byte
   a_row_on_byte_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && row_done_ff |-> byte_done_ff)
      else $error("row end not on byte end");

   // Pixels of one byte follow without a gap
   a_no_gap_in_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_stall && !byte_done_ff |=> rsp_valid_ff)
      else $error("gap inside a byte's pixels");

endmodule

// ===== src/mono_bitmap_pixel_expander.sv =====
// ----------------------------------------------------------------------------
// Mono bitmap pixel expander
// Expands a 1-bit-per-pixel bitmap, one byte per item, into byte-swapped
// RGB565 pixels, one pixel per result item.
// ----------------------------------------------------------------------------
//  channel | ports                          | direction | carries
//  --------+--------------------------------+-----------+----------------------
//  req     | req_valid/req_stall            | in        | one bitmap byte
//  rsp     | rsp_valid/rsp_stall            | out       | one pixel and flags
//  csr     | csr_write_enable/index/data    | in        | colours and sides
//
// Each byte yields 1 to 8 pixels, min(8, width - column); the back emits one
// pixel per cycle while rsp_stall is low. The front takes a byte every cycle
// until the queue (QUEUE_DEPTH_P entries) is full; an accepted byte passes
// the queue and the current-byte register before its first output pixel.
// Reset is synchronous and clears counters, queue and output valid; the
// configuration returns to fg 0x0000, bg 0xFFFF, width 1, height 1.
// rsp_stall holds the output register; req_stall rises only on a full queue.
// ----------------------------------------------------------------------------
module mono_bitmap_pixel_expander
   import mbpe_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH_P = QUEUE_DEPTH
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [COLOUR_W-1:0]  csr_write_data,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [7:0]           req_image_byte,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [COLOUR_W-1:0]  rsp_pixel_word,
   output logic                 rsp_byte_done,
   output logic                 rsp_row_done,
   output logic                 rsp_image_done
);

   logic [COLOUR_W-1:0] fg_ff;
   logic [COLOUR_W-1:0] bg_ff;
   logic [SIDE_W-1:0]   width_ff;
   logic [SIDE_W-1:0]   height_ff;

   logic      push;
   entry_type push_entry;
   logic      pop;
   logic      q_full;
   logic      q_not_empty;
   entry_type q_head;

   // Configuration registers; high data bits of the side writes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         fg_ff     <= FG_RESET;
         bg_ff     <= BG_RESET;
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_FG_COLOUR:    fg_ff     <= csr_write_data;
            CSR_BG_COLOUR:    bg_ff     <= csr_write_data;
            CSR_IMAGE_WIDTH:  width_ff  <= csr_write_data[SIDE_W-1:0];
            CSR_IMAGE_HEIGHT: height_ff <= csr_write_data[SIDE_W-1:0];
            default: ;
         endcase
      end
   end

   mbpe_front u_front (
      .clock          (clock),
      .reset          (reset),
      .image_width    (width_ff),
      .image_height   (height_ff),
      .req_valid      (req_valid),
      .req_image_byte (req_image_byte),
      .queue_full     (q_full),
      .req_stall      (req_stall),
      .push           (push),
      .push_entry     (push_entry)
   );

   mbpe_queue #(
      .DEPTH (QUEUE_DEPTH_P)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (q_full),
      .not_empty  (q_not_empty),
      .head       (q_head)
   );

   mbpe_back u_back (
      .clock          (clock),
      .reset          (reset),
      .fg_colour      (fg_ff),
      .bg_colour      (bg_ff),
      .q_not_empty    (q_not_empty),
      .q_head         (q_head),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_pixel_word (rsp_pixel_word),
      .rsp_byte_done  (rsp_byte_done),
      .rsp_row_done   (rsp_row_done),
      .rsp_image_done (rsp_image_done)
   );

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mono bitmap pixel expander testbench
// Feeds bitmap bytes under several image sizes and colour settings, predicts
// the byte-swapped pixels and the byte, row and image end flags, and checks
// every pixel against the prediction in order, under random and long stalls.
// ----------------------------------------------------------------------------
module testbench;
   import mbpe_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned MAX_REPORTS = 10;
   localparam int unsigned DRAIN_SLACK = 4;
   localparam int unsigned END_SLACK   = 20;

   // One expected pixel with its end flags
   typedef struct packed {
      logic [COLOUR_W-1:0] word;
      logic                byte_done;
      logic                row_done;
      logic                image_done;
   } pixel_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_FG_COLOUR;
   logic [COLOUR_W-1:0]  csr_write_data = '0;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [7:0]           req_image_byte = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [COLOUR_W-1:0]  rsp_pixel_word;
   logic                 rsp_byte_done;
   logic                 rsp_row_done;
   logic                 rsp_image_done;

   // Predictor state: registers and counters as the block should hold them
   logic [COLOUR_W-1:0] fg_model;
   logic [COLOUR_W-1:0] bg_model;
   logic [SIDE_W-1:0]   width_model;
   logic [SIDE_W-1:0]   height_model;
   logic [SIDE_W-1:0]   column_model;
   logic [SIDE_W-1:0]   row_model;

   pixel_type pending_pixels[$];

   int unsigned sender_idle_pct = 0;
   int unsigned stall_pct = 0;
   int unsigned hold_left = 0;
   int unsigned cycle_count = 0;
   int unsigned error_count = 0;
   int unsigned bytes_sent = 0;
   int unsigned pixels_checked = 0;
   int unsigned images_seen = 0;
   int unsigned csr_writes = 0;

   mono_bitmap_pixel_expander dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_image_byte   (req_image_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pixel_word   (rsp_pixel_word),
      .rsp_byte_done    (rsp_byte_done),
      .rsp_row_done     (rsp_row_done),
      .rsp_image_done   (rsp_image_done)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Zero acts as one, anything above the limit saturates
   function automatic int unsigned effective_side(input logic [SIDE_W-1:0] v);
      int unsigned s;
      s = 32'(v);
      if (s == 0) begin
         s = 1;
      end else if (s > MAX_SIDE) begin
         s = MAX_SIDE;
      end
      return s;
   endfunction

   // Expected pixels of one accepted byte; advances the column and row counters
   function automatic void expand_byte(input logic [7:0] bits);
      int unsigned w;
      int unsigned h;
      int unsigned col;
      int unsigned row;
      int unsigned remaining;
      int unsigned count;
      logic        ends_row;
      logic        ends_image;
      logic [COLOUR_W-1:0] colour;
      pixel_type   px;
      w = effective_side(width_model);
      h = effective_side(height_model);
      col = 32'(column_model);
      row = 32'(row_model);
      // stale counters restart before the byte is used
      if (col >= w) begin
         col = 0;
      end
      if (row >= h) begin
         row = 0;
      end
      remaining = w - col;
      count = (remaining < 8) ? remaining : 8;
      ends_row = (count == remaining);
      ends_image = ends_row && (row + 1 == h);
      for (int k = 0; k < count; k++) begin
         colour = bits[7-k] ? bg_model : fg_model;
         px.word = {colour[7:0], colour[15:8]};
         px.byte_done = (k + 1 == count);
         px.row_done = px.byte_done && ends_row;
         px.image_done = px.byte_done && ends_image;
         pending_pixels.push_back(px);
      end
      if (ends_row) begin
         column_model = '0;
         row_model = ends_image ? '0 : SIDE_W'(row + 1);
      end else begin
         column_model = SIDE_W'(col + count);
         row_model = SIDE_W'(row);
      end
   endfunction

   // Offer one byte, idling first at the sender's rate, and wait for acceptance
   task automatic send_byte(input logic [7:0] bits);
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid = 1'b0;
         req_image_byte = 8'($urandom);
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_image_byte = bits;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      expand_byte(bits);
      bytes_sent++;
   endtask

   // Stop offering and wait until every expected pixel has arrived
   task automatic wait_drained;
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_pixels.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_SLACK) @(posedge clock);
   endtask

   // Register write; only called while the block is idle
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [COLOUR_W-1:0] data);
      @(negedge clock);
      req_valid = 1'b0;
      csr_write_enable = 1'b1;
      csr_index = idx;
      csr_write_data = data;
      @(negedge clock);
      csr_write_enable = 1'b0;
      case (idx)
         CSR_FG_COLOUR:    fg_model = data;
         CSR_BG_COLOUR:    bg_model = data;
         CSR_IMAGE_WIDTH:  width_model = data[SIDE_W-1:0];
         CSR_IMAGE_HEIGHT: height_model = data[SIDE_W-1:0];
         default: ;
      endcase
      csr_writes++;
   endtask

   task automatic set_geometry(input logic [COLOUR_W-1:0] w, input logic [COLOUR_W-1:0] h);
      write_csr(CSR_IMAGE_WIDTH, w);
      write_csr(CSR_IMAGE_HEIGHT, h);
   endtask

   task automatic set_idling(input int unsigned sender_pct, input int unsigned recv_pct);
      sender_idle_pct = sender_pct;
      stall_pct = recv_pct;
   endtask

   // Side value for random settings: mostly small, sometimes the extremes
   function automatic logic [COLOUR_W-1:0] random_side(input int unsigned small_max);
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 70) begin
         return COLOUR_W'($urandom_range(1, small_max));
      end else if (pick < 78) begin
         return '0;
      end else if (pick < 86) begin
         return COLOUR_W'(MAX_SIDE);
      end else begin
         return COLOUR_W'($urandom);
      end
   endfunction

   // ---------------------------------------------------------------- tests

   // Default registers: one-pixel image, black for clear, white for set
   task automatic test_reset_values;
      send_byte(8'h80);
      send_byte(8'h00);
      send_byte(8'h7F);
      send_byte(8'hFF);
      wait_drained();
   endtask

   // Short rows, rows that need a second byte, and both colour extremes
   task automatic test_row_layout;
      write_csr(CSR_FG_COLOUR, 16'h1234);
      write_csr(CSR_BG_COLOUR, 16'hABCD);
      set_geometry(16'd3, 16'd2);
      send_byte(8'hA5);
      send_byte(8'h5A);
      wait_drained();
      write_csr(CSR_FG_COLOUR, 16'hFFFF);
      write_csr(CSR_BG_COLOUR, 16'h0000);
      // bits above the width field are dropped: width 9
      set_geometry(16'hFE09, 16'd2);
      send_byte(8'hFF);
      send_byte(8'h80);
      send_byte(8'h00);
      send_byte(8'h7F);
      wait_drained();
   endtask

   // Zero width and height behave as one
   task automatic test_zero_size;
      set_geometry(16'd0, 16'd0);
      send_byte(8'h01);
      send_byte(8'hFE);
      wait_drained();
   endtask

   // Shrinking the sides mid-image restarts the column, then the row
   task automatic test_stale_counters;
      set_geometry(16'd20, 16'd3);
      send_byte(8'hC3);
      send_byte(8'h3C);
      wait_drained();
      write_csr(CSR_IMAGE_WIDTH, 16'd10);
      send_byte(8'h96);
      send_byte(8'h69);
      wait_drained();
      write_csr(CSR_IMAGE_HEIGHT, 16'd1);
      send_byte(8'hF0);
      send_byte(8'h0F);
      send_byte(8'h55);
      wait_drained();
   endtask

   // Writes past the last register change nothing
   task automatic test_unused_index;
      for (int i = CSR_IMAGE_HEIGHT + 1; i < (1 << CSR_IDX_W); i++) begin
         write_csr(CSR_IDX_W'(i), 16'hFFFF);
      end
      send_byte(8'hAA);
      send_byte(8'h33);
      wait_drained();
   endtask

   // Full-size rows and a saturated height, both reached by saturation
   task automatic test_max_side;
      set_idling(0, 0);
      write_csr(CSR_FG_COLOUR, 16'($urandom));
      write_csr(CSR_BG_COLOUR, 16'($urandom));
      set_geometry(16'hFFFF, 16'd2);
      repeat (2 * MAX_SIDE / 8) send_byte(8'($urandom));
      wait_drained();
      set_idling(12, 12);
      set_geometry(16'd321, 16'h01FF);
      repeat (2 * MAX_SIDE / 8 + 2) send_byte(8'($urandom));
      wait_drained();
   endtask

   // Receiver holds off for a long stretch while bytes keep coming
   task automatic test_backpressure;
      set_idling(0, 0);
      set_geometry(16'd64, 16'd2);
      hold_left = 300;
      repeat (40) send_byte(8'($urandom));
      wait_drained();
   endtask

   // Random settings and bytes under each idling mix
   task automatic test_random_traffic;
      int unsigned sender_pcts[4] = '{0, 67, 0, 12};
      int unsigned recv_pcts[4]   = '{0, 0, 67, 12};
      for (int p = 0; p < 4; p++) begin
         set_idling(sender_pcts[p], recv_pcts[p]);
         repeat (2) begin
            write_csr(CSR_FG_COLOUR, 16'($urandom));
            write_csr(CSR_BG_COLOUR, 16'($urandom));
            set_geometry(random_side(24), random_side(4));
            repeat (30) send_byte(8'($urandom));
            // bursts with no idling at all
            set_idling(0, 0);
            repeat (8) send_byte(8'($urandom));
            set_idling(sender_pcts[p], recv_pcts[p]);
            wait_drained();
         end
      end
   endtask

   // ------------------------------------------------------------ processes

   // Receiver stall: random, or a counted hold-off when one is requested
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall = 1'b1;
         hold_left--;
      end else begin
         rsp_stall = ($urandom_range(99) < stall_pct);
      end
   end

   // Compare each accepted pixel with the oldest expectation
   always @(posedge clock) begin
      pixel_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_pixels.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS) begin
               $display("unexpected pixel %h flags %b%b%b at cycle %0d", rsp_pixel_word,
                        rsp_byte_done, rsp_row_done, rsp_image_done, cycle_count);
            end
         end else begin
            want = pending_pixels.pop_front();
            pixels_checked++;
            if (rsp_image_done === 1'b1) begin
               images_seen++;
            end
            if (rsp_pixel_word !== want.word || rsp_byte_done !== want.byte_done ||
                rsp_row_done !== want.row_done || rsp_image_done !== want.image_done) begin
               error_count++;
               if (error_count <= MAX_REPORTS) begin
                  $display("pixel mismatch at cycle %0d: expected %h %b%b%b, got %h %b%b%b",
                           cycle_count, want.word, want.byte_done, want.row_done,
                           want.image_done, rsp_pixel_word, rsp_byte_done,
                           rsp_row_done, rsp_image_done);
               end
            end
         end
      end
   end

   // Watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d pixels outstanding", cycle_count,
               pending_pixels.size());
      $display("== FAIL ==");
      $finish;
   end

   // Main sequence
   initial begin
      fg_model = FG_RESET;
      bg_model = BG_RESET;
      width_model = WIDTH_RESET;
      height_model = HEIGHT_RESET;
      column_model = '0;
      row_model = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_values();
      test_row_layout();
      test_zero_size();
      test_stale_counters();
      test_unused_index();
      test_backpressure();
      test_max_side();
      test_random_traffic();

      wait_drained();
      repeat (END_SLACK) @(posedge clock);
      if (pending_pixels.size() != 0) begin
         error_count++;
      end

      $display("Expanded %0d bitmap bytes into %0d checked pixels, %0d whole images,",
               bytes_sent, pixels_checked, images_seen);
      $display("across %0d register writes; %0d mismatches.", csr_writes, error_count);
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
